@@ rtl/smfd_pkg.sv @@
// shared constants, microcode word type and control store for the modulated delay unit
package smfd_pkg;

  localparam int unsigned SampleW    = 24;
  localparam int unsigned AmtW       = 17;
  localparam int unsigned DelayLen   = 1024;
  localparam int unsigned RingLen    = 2 * DelayLen;
  localparam int unsigned AddrW      = $clog2(RingLen);
  localparam int unsigned FracW      = 16;
  localparam int unsigned WholeW     = $clog2(DelayLen) + 1;
  localparam int unsigned DW         = WholeW + FracW;
  localparam int unsigned DelayShift = SampleW - $clog2(DelayLen);
  localparam int unsigned ProdW      = SampleW + AmtW + 1;
  localparam int unsigned TW         = ProdW + 1;
  localparam int unsigned AccW       = ProdW + 1;
  localparam int unsigned RndW       = AccW - FracW;
  localparam int unsigned StepW      = 4;

  localparam logic [AmtW-1:0]        AmtReset = AmtW'(65536);
  localparam logic [AmtW:0]          FracOne  = (AmtW + 1)'(1 << FracW);
  localparam logic signed [TW-1:0]   TOne     = TW'(64'd1 << (SampleW + 15));
  localparam logic signed [TW-1:0]   TTwo     = TW'(64'd1 << (SampleW + 16));
  localparam logic [DW-1:0]          DMax     = DW'(DelayLen) << FracW;
  localparam logic signed [AccW-1:0] RndBias  = AccW'(1 << (FracW - 1));
  localparam logic signed [RndW-1:0] RndMax   = RndW'(2 ** (SampleW - 1) - 1);
  localparam logic signed [RndW-1:0] RndMin   = -RndMax - RndW'(1);

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_AMT_LMOD,
    MUL_AMT_RMOD,
    MUL_HL_WL,
    MUL_HL_FL,
    MUL_HR_WR,
    MUL_HR_FR
  } mul_sel_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_L0,
    RD_L1,
    RD_R0,
    RD_R1
  } rd_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_NO_IN,
    WAIT_OUT_BUSY
  } wait_e;

  typedef struct packed {
    wait_e    wait_c;
    logic     accept;
    logic     mem_wr;
    mul_sel_e mul_sel;
    logic     dly_l;
    logic     dly_r;
    rd_sel_e  rd_sel;
    acc_op_e  acc_op;
    logic     keep_l;
    logic     push;
    logic     last;
  } ucode_t;

  // control store, one word per step
  function automatic ucode_t ucode_rom(logic [StepW-1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      StepW'(0): begin
        w.wait_c = WAIT_NO_IN;
        w.accept = 1'b1;
      end
      StepW'(1): begin
        w.mem_wr  = 1'b1;
        w.mul_sel = MUL_AMT_LMOD;
      end
      StepW'(2): begin
        w.mul_sel = MUL_AMT_RMOD;
        w.dly_l   = 1'b1;
      end
      StepW'(3): begin
        w.dly_r  = 1'b1;
        w.rd_sel = RD_L0;
      end
      StepW'(4): begin
        w.rd_sel  = RD_L1;
        w.mul_sel = MUL_HL_WL;
      end
      StepW'(5): begin
        w.rd_sel  = RD_R0;
        w.mul_sel = MUL_HL_FL;
        w.acc_op  = ACC_LOAD;
      end
      StepW'(6): begin
        w.rd_sel  = RD_R1;
        w.mul_sel = MUL_HR_WR;
        w.acc_op  = ACC_ADD;
      end
      StepW'(7): begin
        w.mul_sel = MUL_HR_FR;
        w.acc_op  = ACC_LOAD;
        w.keep_l  = 1'b1;
      end
      StepW'(8): begin
        w.acc_op = ACC_ADD;
      end
      StepW'(9): begin
        w.wait_c = WAIT_OUT_BUSY;
        w.push   = 1'b1;
        w.last   = 1'b1;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

  // round result clamp to the sample range
  function automatic logic signed [SampleW-1:0] sat_sample(logic signed [RndW-1:0] v);
    logic signed [RndW-1:0] c;
    c = v;
    if (v > RndMax) c = RndMax;
    if (v < RndMin) c = RndMin;
    return c[SampleW-1:0];
  endfunction

endpackage

@@ rtl/smfd_if.sv @@
// valid/ready channel interfaces for input frames, results and configuration
interface smfd_in_if import smfd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_in;
  logic signed [SampleW-1:0] right_in;
  logic signed [SampleW-1:0] left_mod;
  logic signed [SampleW-1:0] right_mod;

  modport source (output valid, left_in, right_in, left_mod, right_mod, input ready);
  modport sink   (input valid, left_in, right_in, left_mod, right_mod, output ready);
endinterface

interface smfd_out_if import smfd_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] left_out;
  logic signed [SampleW-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface smfd_cfg_if import smfd_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [AmtW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/smfd_ram.sv @@
// simple dual-port ram, one write port and one registered read port
module smfd_ram #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned Width = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ rtl/stereo_modulated_fractional_delay_unit.sv @@
// top level of the stereo modulated fractional delay unit
//
// Each input beat carries one stereo audio frame and one stereo modulator frame. Both new
// samples are written into a shared 2048-entry history ring (left and right side by side),
// then each channel is read back at the fractional delay
// d = 512 * (1 - mod_amount * mod), clamped to [0, 1024] with a 16-bit fraction, and the two
// neighboring samples are blended linearly with round-to-nearest and saturation. One output
// beat follows every input beat. The work is driven by a ten-step microcode program that
// steers one shared 24x18 multiplier, one delay/clamp unit, an accumulator and the single
// read port of the history ram: a frame runs from the accepting step to the result
// register, and the next frame is taken only once the program is back at its first step,
// later while the output register holds an untaken result. Unwritten ring entries read
// as zero; a write pointer and a wrap flag track this, so no clearing pass runs after reset.
// The modulation depth register resets to full depth (65536) and should be written only
// while the unit is idle; the configuration channel is always ready.
module stereo_modulated_fractional_delay_unit import smfd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  smfd_in_if.sink           in_i,
  smfd_out_if.source        out_o,
  smfd_cfg_if.sink          cfg_i
);

  // sequencer
  logic [StepW-1:0] step_q, step_d;
  ucode_t           uc;
  logic             stall;
  logic             go;

  // control and status registers
  logic [AmtW-1:0]  amt_q, amt_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic             wrapped_q, wrapped_d;
  logic             out_valid_q, out_valid_d;
  logic             rd_ok_q, rd_ok_d;

  // payload registers
  logic signed [SampleW-1:0] l_in_q, r_in_q, l_mod_q, r_mod_q;
  logic signed [ProdW-1:0]   prod_q;
  logic signed [AccW-1:0]    acc_q;
  logic [WholeW-1:0]         l_whole_q, r_whole_q;
  logic [FracW-1:0]          l_frac_q, r_frac_q;
  logic signed [SampleW-1:0] l_res_q;
  logic signed [SampleW-1:0] out_l_q, out_r_q;

  // datapath signals
  logic                      rd_en;
  logic [AddrW-1:0]          rd_addr;
  logic [AddrW-1:0]          l_i0, l_i1, r_i0, r_i1;
  logic [2*SampleW-1:0]      rdata;
  logic signed [SampleW-1:0] hist_l, hist_r;
  logic signed [SampleW-1:0] a_op;
  logic signed [AmtW:0]      b_op;
  logic signed [ProdW-1:0]   prod_d;
  logic signed [TW-1:0]      t_val;
  logic [DW-1:0]             dly;
  logic signed [AccW-1:0]    rnd_sum;
  logic signed [RndW-1:0]    rnd;
  logic signed [SampleW-1:0] rnd_sat;

  assign uc = ucode_rom(step_q);

  // conditional wait: hold the step and suppress its actions
  always_comb begin
    case (uc.wait_c)
      WAIT_NO_IN:    stall = !in_i.valid;
      WAIT_OUT_BUSY: stall = out_valid_q && !out_o.ready;
      default:       stall = 1'b0;
    endcase
  end

  assign go = !stall;

  assign in_i.ready  = uc.accept;
  assign cfg_i.ready = 1'b1;

  // ring addresses for the two taps of each channel
  assign l_i0 = wp_q - AddrW'(l_whole_q);
  assign l_i1 = l_i0 - AddrW'(1);
  assign r_i0 = wp_q - AddrW'(r_whole_q);
  assign r_i1 = r_i0 - AddrW'(1);

  always_comb begin
    case (uc.rd_sel)
      RD_L0:   rd_addr = l_i0;
      RD_L1:   rd_addr = l_i1;
      RD_R0:   rd_addr = r_i0;
      RD_R1:   rd_addr = r_i1;
      default: rd_addr = '0;
    endcase
  end

  assign rd_en = go && (uc.rd_sel != RD_NONE);

  // entries past the write pointer before the first wrap were never written and read as zero
  assign rd_ok_d = wrapped_q || (rd_addr <= wp_q);

  smfd_ram #(
    .Depth (RingLen),
    .Width (2 * SampleW)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (go && uc.mem_wr),
    .waddr_i (wp_q),
    .wdata_i ({l_in_q, r_in_q}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign hist_l = rd_ok_q ? rdata[2*SampleW-1:SampleW] : '0;
  assign hist_r = rd_ok_q ? rdata[SampleW-1:0] : '0;

  // operand select for the shared multiplier
  always_comb begin
    case (uc.mul_sel)
      MUL_AMT_LMOD: begin
        a_op = l_mod_q;
        b_op = {1'b0, amt_q};
      end
      MUL_AMT_RMOD: begin
        a_op = r_mod_q;
        b_op = {1'b0, amt_q};
      end
      MUL_HL_WL: begin
        a_op = hist_l;
        b_op = FracOne - (AmtW + 1)'(l_frac_q);
      end
      MUL_HL_FL: begin
        a_op = hist_l;
        b_op = (AmtW + 1)'(l_frac_q);
      end
      MUL_HR_WR: begin
        a_op = hist_r;
        b_op = FracOne - (AmtW + 1)'(r_frac_q);
      end
      MUL_HR_FR: begin
        a_op = hist_r;
        b_op = (AmtW + 1)'(r_frac_q);
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
  end

  assign prod_d = a_op * b_op;

  // delay in q.16 from the registered depth product, clamped to [0, DelayLen]
  assign t_val = TOne - TW'(prod_q);

  always_comb begin
    if (t_val[TW-1] || (t_val == TW'(0))) begin
      dly = '0;
    end else if (t_val >= TTwo) begin
      dly = DMax;
    end else begin
      dly = t_val[DelayShift +: DW];
    end
  end

  // round to nearest, ties up, then clamp
  assign rnd_sum = acc_q + RndBias;
  assign rnd     = rnd_sum[AccW-1:FracW];
  assign rnd_sat = sat_sample(rnd);

  // next state of control registers
  always_comb begin
    step_d      = step_q;
    amt_d       = amt_q;
    wp_d        = wp_q;
    wrapped_d   = wrapped_q;
    out_valid_d = out_valid_q;

    if (go) begin
      step_d = uc.last ? '0 : step_q + StepW'(1);
    end
    if (cfg_i.valid) begin
      amt_d = cfg_i.data;
    end
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (go && uc.push) begin
      out_valid_d = 1'b1;
      wp_d        = wp_q + AddrW'(1);
      if (&wp_q) begin
        wrapped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      amt_q       <= AmtReset;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      rd_ok_q     <= 1'b0;
    end else begin
      step_q      <= step_d;
      amt_q       <= amt_d;
      wp_q        <= wp_d;
      wrapped_q   <= wrapped_d;
      out_valid_q <= out_valid_d;
      if (rd_en) begin
        rd_ok_q <= rd_ok_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (go && uc.accept) begin
      l_in_q  <= in_i.left_in;
      r_in_q  <= in_i.right_in;
      l_mod_q <= in_i.left_mod;
      r_mod_q <= in_i.right_mod;
    end
    if (go && (uc.mul_sel != MUL_NONE)) begin
      prod_q <= prod_d;
    end
    if (go && uc.dly_l) begin
      l_whole_q <= dly[DW-1:FracW];
      l_frac_q  <= dly[FracW-1:0];
    end
    if (go && uc.dly_r) begin
      r_whole_q <= dly[DW-1:FracW];
      r_frac_q  <= dly[FracW-1:0];
    end
    if (go) begin
      case (uc.acc_op)
        ACC_LOAD: acc_q <= AccW'(prod_q);
        ACC_ADD:  acc_q <= acc_q + AccW'(prod_q);
        default:  acc_q <= acc_q;
      endcase
    end
    if (go && uc.keep_l) begin
      l_res_q <= rnd_sat;
    end
    if (go && uc.push) begin
      out_l_q <= l_res_q;
      out_r_q <= rnd_sat;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.left_out  = out_l_q;
  assign out_o.right_out = out_r_q;

`ifndef SYNTHESIS
  // an accepted frame starts the program at its first working step
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (step_q == StepW'(1)))
    else $error("accepted beat did not start the program");

  // a result never overwrites one that is still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && uc.push) |-> (!out_valid_q || out_o.ready))
    else $error("result register overwritten");

  // clamped left delay never reaches past the ring window
  a_delay_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == StepW'(3)) |-> (l_whole_q <= WholeW'(DelayLen)))
    else $error("left delay out of range");

  // once the ring has wrapped, every read is of written data
  a_wrapped_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wrapped_q && rd_en) |=> rd_ok_q)
    else $error("read masked after ring wrap");
`endif

endmodule

@@ test/stereo_modulated_fractional_delay_unit_tb.sv @@
// self-checking testbench for the stereo modulated fractional delay unit
module stereo_modulated_fractional_delay_unit_tb;
  import smfd_pkg::*;

  localparam logic signed [SampleW-1:0] SMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SMin = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic [AmtW-1:0] AmtFull = AmtW'(65536);
  localparam logic [AmtW-1:0] AmtTop  = {AmtW{1'b1}};
  localparam int DrainCycles = 16;
  localparam int LimitTime   = 2_000_000;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
    logic signed [SampleW-1:0] left_mod;
    logic signed [SampleW-1:0] right_mod;
  } frame_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } stereo_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_LONG_STALL, RX_RARE_DROP} rx_mode_e;

  // mirrors both history rings and the depth register, queues the interpolated outputs
  class delay_scoreboard;
    logic signed [SampleW-1:0] left_ring  [RingLen];
    logic signed [SampleW-1:0] right_ring [RingLen];
    logic [AddrW-1:0]          wr_pos;
    logic [AmtW-1:0]           depth;
    stereo_t                   expected [$];
    int frames, results, mismatches, wraps, zero_taps, full_taps, depth_writes;

    function new();
      foreach (left_ring[i]) begin
        left_ring[i]  = '0;
        right_ring[i] = '0;
      end
      wr_pos = '0;
      depth  = AmtReset;
    endfunction

    function void set_depth(logic [AmtW-1:0] v);
      depth = v;
      depth_writes++;
    endfunction

    // delay in q.16, clamped to [0, DelayLen]
    function longint delay_q16(logic signed [SampleW-1:0] m);
      longint one, t, d;
      one = longint'(1) << (SampleW + 15);
      t = one - longint'(depth) * longint'(m);
      if (t <= 0) begin
        zero_taps++;
        return 0;
      end
      if (t >= 2 * one) begin
        full_taps++;
        return longint'(DelayLen) << FracW;
      end
      d = (longint'(DelayLen) * t) >>> SampleW;
      if (d > (longint'(DelayLen) << FracW)) d = longint'(DelayLen) << FracW;
      return d;
    endfunction

    function logic signed [SampleW-1:0] tap(bit right_side, logic signed [SampleW-1:0] sample,
                                            logic signed [SampleW-1:0] m);
      longint d, f, h0, h1, acc, res;
      int pos, whole, i0, i1;
      d = delay_q16(m);
      whole = int'(d >>> FracW);
      f = d & 64'hFFFF;
      pos = int'(wr_pos);
      if (right_side) right_ring[pos] = sample;
      else left_ring[pos] = sample;
      i0 = (pos + RingLen - whole) % RingLen;
      i1 = (pos + 2 * RingLen - whole - 1) % RingLen;
      h0 = right_side ? right_ring[i0] : left_ring[i0];
      h1 = right_side ? right_ring[i1] : left_ring[i1];
      acc = h0 * (65536 - f) + h1 * f;
      res = (acc + 32768) >>> 16;
      if (res > longint'(SMax)) res = longint'(SMax);
      if (res < longint'(SMin)) res = longint'(SMin);
      return res[SampleW-1:0];
    endfunction

    function void note_frame(frame_t fr);
      stereo_t r;
      r.left  = tap(1'b0, fr.left_in, fr.left_mod);
      r.right = tap(1'b1, fr.right_in, fr.right_mod);
      wr_pos = wr_pos + 1'b1;
      if (wr_pos == '0) wraps++;
      expected.push_back(r);
      frames++;
    endfunction

    function void check_result(logic signed [SampleW-1:0] l, logic signed [SampleW-1:0] r);
      stereo_t e;
      results++;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat %0d: left %0d right %0d", results, l, r);
        return;
      end
      e = expected.pop_front();
      if (l !== e.left || r !== e.right) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at result %0d: left exp %0d got %0d, right exp %0d got %0d",
                   results, e.left, l, e.right, r);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  smfd_in_if  in_bus ();
  smfd_out_if out_bus ();
  smfd_cfg_if cfg_bus ();

  stereo_modulated_fractional_delay_unit u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source),
    .cfg_i  (cfg_bus.sink)
  );

  delay_scoreboard sb = new();

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sample all handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) sb.set_depth(cfg_bus.data);
      if (in_bus.valid && in_bus.ready) sb.note_frame({in_bus.left_in, in_bus.right_in,
                                                       in_bus.left_mod, in_bus.right_mod});
      if (out_bus.valid && out_bus.ready) sb.check_result(out_bus.left_out, out_bus.right_out);
    end
  end

  // receiver backpressure, in one of four randomly chosen modes at a time
  initial begin
    rx_mode_e mode;
    int hold;
    out_bus.ready = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      repeat (64) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:      out_bus.ready = 1'b1;
          RX_COIN:      out_bus.ready = 1'($urandom_range(0, 1));
          RX_RARE_DROP: out_bus.ready = ($urandom_range(0, 7) != 0);
          default: begin
            if (hold == 0) begin
              out_bus.ready = ~out_bus.ready;
              hold = out_bus.ready ? $urandom_range(1, 10) : $urandom_range(1, 30);
            end else begin
              hold--;
            end
          end
        endcase
      end
    end
  end

  initial begin
    #(LimitTime);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic frame_t mk(logic signed [SampleW-1:0] l, logic signed [SampleW-1:0] r,
                                logic signed [SampleW-1:0] lm, logic signed [SampleW-1:0] rm);
    frame_t fr;
    fr.left_in   = l;
    fr.right_in  = r;
    fr.left_mod  = lm;
    fr.right_mod = rm;
    return fr;
  endfunction

  function automatic logic signed [SampleW-1:0] rand_mod();
    logic signed [SampleW-1:0] v;
    v = SampleW'($urandom);
    case ($urandom_range(0, 9))
      4: v = $signed(SampleW'($urandom_range(0, 511))) - SampleW'(256);
      5: case ($urandom_range(0, 2))
           0: v = SMax;
           1: v = SMin;
           default: v = '0;
         endcase
      6: v = $urandom_range(0, 1) ? SMax - SampleW'($urandom_range(0, 1023))
                                  : SMin + SampleW'($urandom_range(0, 1023));
      7: v = $urandom_range(0, 1) ? (SampleW'(1) << $urandom_range(0, SampleW - 2))
                                  : -(SampleW'(1) << $urandom_range(0, SampleW - 1));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    logic signed [SampleW-1:0] v;
    v = SampleW'($urandom);
    case ($urandom_range(0, 9))
      7: v = $urandom_range(0, 1) ? SMax : SMin;
      8: v = $signed(SampleW'($urandom_range(0, 63))) - SampleW'(32);
      default: ;
    endcase
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after the beat is taken
  task automatic send_frame(frame_t fr);
    in_bus.valid     = 1'b1;
    in_bus.left_in   = fr.left_in;
    in_bus.right_in  = fr.right_in;
    in_bus.left_mod  = fr.left_mod;
    in_bus.right_mod = fr.right_mod;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    in_bus.valid = 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // only called while the unit is idle
  task automatic write_depth(logic [AmtW-1:0] v);
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = v;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic run_random(int count, int gap_max);
    int sent, burst, stall_at;
    sent = 0;
    stall_at = $urandom_range(count / 4, 3 * count / 4);
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        if (sent < count) begin
          send_frame(mk(rand_sample(), rand_sample(), rand_mod(), rand_mod()));
          sent++;
        end
      end
      // one mid-phase pause until the pipeline is empty
      if (stall_at >= 0 && sent >= stall_at) begin
        stall_at = -1;
        drain();
      end else if (gap_max > 0) begin
        in_bus.valid = 1'b0;
        repeat ($urandom_range(0, gap_max)) @(negedge clk);
      end
    end
  endtask

  task automatic run_directed();
    // reset depth, ring still empty so older taps read zero
    send_frame(mk(SMax, SMin, '0, '0));
    send_frame(mk(SMin, SMax, SMax, SMin));
    send_frame(mk(24'sd1, -24'sd1, -24'sd1, 24'sd1));
    send_frame(mk(24'sh123456, -24'sh123456, 24'sh400000, -24'sh400000));
    send_frame(mk(-24'sd1, '0, SMin, SMax));
    send_frame(mk(SMax, SMax, SMax, SMax));
    send_frame(mk(SMin, SMin, SMin, SMin));
    send_frame(mk('0, '0, 24'sd1, -24'sd1));
    send_frame(mk(24'sh555555, -24'sh2AAAAA, 24'sh000123, -24'sh7FF000));
    drain();
    // depth above full: negative delay on the left, past the end on the right
    write_depth(AmtTop);
    send_frame(mk(24'sh7FF000, -24'sh7FF000, SMax, SMin));
    send_frame(mk(SMin, SMax, SMin, SMax));
    send_frame(mk(24'sh0F0F0F, -24'sh0F0F0F, 24'sh200000, -24'sh200000));
    send_frame(mk(SMax, SMin, '0, '0));
    send_frame(mk(24'sd7, -24'sd7, 24'sd1, 24'sd1));
    send_frame(mk(-24'sh400000, 24'sh3FFFFF, 24'sh400000, -24'sh400001));
    drain();
    // zero depth: delay fixed at half length whatever the modulator
    write_depth('0);
    send_frame(mk(SMax, SMin, SMax, SMin));
    send_frame(mk(SMin, SMax, SMin, SMax));
    send_frame(mk(24'sd100, -24'sd100, 24'sh0ABCDE, -24'sd5));
    drain();
  endtask

  initial begin
    logic [AmtW-1:0] depths [7];
    int counts [7];
    int gaps [7];
    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.left_in   = '0;
    in_bus.right_in  = '0;
    in_bus.left_mod  = '0;
    in_bus.right_mod = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data  = '0;
    depths = '{AmtFull, AmtTop, AmtW'(1), AmtW'($urandom_range(0, 131071)), AmtW'(32768),
               '0, AmtW'($urandom_range(65537, 131071))};
    // frames per depth phase, about nine hundred in all with the directed ones
    counts = '{140, 120, 40, 130, 130, 40, 280};
    gaps   = '{12, 20, 0, 8, 20, 4, 12};
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    foreach (depths[i]) begin
      write_depth(depths[i]);
      run_random(counts[i], gaps[i]);
      drain();
    end

    $display("covered %0d frames over %0d depth writes, history ring wrapped %0d time(s)",
             sb.frames, sb.depth_writes, sb.wraps);
    $display("taps clamped to zero delay %0d times and to full length %0d times",
             sb.zero_taps, sb.full_taps);
    if (sb.mismatches == 0 && sb.expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatching beats, %0d results still owed",
               sb.mismatches, sb.expected.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
